### sv/bgb_pkg.sv
package bgb_pkg;

   localparam int MAX_GLYPH_ROWS_DEF = 16;
   localparam int GLYPH_COUNT        = 256;
   localparam int GLYPH_WIDTH        = 8;
   localparam int STORE_AW           = 12;
   localparam int ADDR_W             = 28;
   localparam int CSR_AW             = 5;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_DRAW = 1'b1;

   localparam logic [1:0] MODE_REPLACE = 2'd0;
   localparam logic [1:0] MODE_XOR     = 2'd1;
   localparam logic [1:0] MODE_OR      = 2'd2;
   localparam logic [1:0] MODE_SET     = 2'd3;

   localparam logic [2:0] REG_SURFACE_WIDTH  = 3'd0;
   localparam logic [2:0] REG_SURFACE_HEIGHT = 3'd1;
   localparam logic [2:0] REG_BYTES_PER_LINE = 3'd2;
   localparam logic [2:0] REG_TEXT_COLOR     = 3'd3;
   localparam logic [2:0] REG_DRAW_MODE      = 3'd4;
   localparam logic [2:0] REG_GLYPH_HEIGHT   = 3'd5;
   localparam logic [2:0] REG_FONT_PRESENT   = 3'd6;

   typedef struct packed {
      logic [12:0] surface_width;
      logic [12:0] surface_height;
      logic [15:0] bytes_per_line;
      logic [7:0]  text_color;
      logic [1:0]  draw_mode;
      logic [4:0]  glyph_height;
      logic        font_present;
   } cfg_type;

   typedef struct packed {
      logic                en;
      logic [STORE_AW-1:0] addr;
      logic [7:0]          data;
   } store_wr_type;

   typedef struct packed {
      logic                en;
      logic [STORE_AW-1:0] addr;
   } store_rd_type;

endpackage

### sv/bitmap_glyph_blitter.sv
// 8-pixel-wide glyph blitter for an 8-bit framebuffer.
// req channel: opcode 0 writes font_byte into the glyph store at font_address;
// opcode 1 draws char_code with its top-left corner at (pos_x, pos_y).
// rsp channel: one transaction per visible glyph row, carrying the byte offset
// y*pitch+x, the pixel mask, the raster op and its value; last_row marks the
// final row of a character. Fully clipped draws and draws without a font
// give no transaction.
// csr port: APB-style, surface size, pitch, colour, mode, glyph height and
// font-present flag at byte offsets 0x00..0x18; pready is always high.
// Sequence: a load is written into the glyph store on acceptance. A draw first
// computes clipping and products (ST_CLIP), then the base offset and store index
// (ST_BASE), then reads one row per cycle through the shared adders while the
// output is not stalled, each row passing through the read register and then the
// output register; a fully clipped draw returns to idle after ST_CLIP.
// req_ready is low while a draw is in progress. When rsp_ready is held low the
// row pipeline stops with one row in the output register and one in the read register.
// Reset restores the register defaults and returns to idle; the glyph store
// is not cleared and must be loaded before use.
module bitmap_glyph_blitter #(
   parameter int MAX_GLYPH_ROWS = bgb_pkg::MAX_GLYPH_ROWS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_opcode,
   input  logic [11:0]        req_font_address,
   input  logic [7:0]         req_font_byte,
   input  logic signed [15:0] req_pos_x,
   input  logic signed [15:0] req_pos_y,
   input  logic [7:0]         req_char_code,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [27:0]        rsp_row_address,
   output logic [7:0]         rsp_pixel_mask,
   output logic [1:0]         rsp_pixel_op,
   output logic [7:0]         rsp_pixel_value,
   output logic               rsp_last_row,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [4:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);
   import bgb_pkg::*;

   cfg_type      cfg;
   store_wr_type store_wr;
   store_rd_type store_rd;
   logic [7:0]   store_data;

   // font loads go straight into the store
   assign store_wr.en   = req_valid && req_ready && (req_opcode == OP_LOAD);
   assign store_wr.addr = req_font_address;
   assign store_wr.data = req_font_byte;

   bgb_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   bgb_glyph_store u_store (
      .clock   (clock),
      .wr      (store_wr),
      .rd      (store_rd),
      .rd_data (store_data)
   );

   bgb_row_engine #(
      .MAX_GLYPH_ROWS (MAX_GLYPH_ROWS)
   ) u_engine (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_opcode      (req_opcode),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_char_code   (req_char_code),
      .store_rd        (store_rd),
      .store_data      (store_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_row_address (rsp_row_address),
      .rsp_pixel_mask  (rsp_pixel_mask),
      .rsp_pixel_op    (rsp_pixel_op),
      .rsp_pixel_value (rsp_pixel_value),
      .rsp_last_row    (rsp_last_row)
   );

endmodule

### sv/bgb_csr.sv
module bgb_csr (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [bgb_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [31:0]               csr_pwdata,
   output logic [31:0]               csr_prdata,
   output logic                      csr_pready,
   output bgb_pkg::cfg_type          cfg
);
   import bgb_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic [2:0] reg_index;
   logic       wr_en;

   assign reg_index  = csr_paddr[4:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_index)
            REG_SURFACE_WIDTH:  cfg_in.surface_width  = csr_pwdata[12:0];
            REG_SURFACE_HEIGHT: cfg_in.surface_height = csr_pwdata[12:0];
            REG_BYTES_PER_LINE: cfg_in.bytes_per_line = csr_pwdata[15:0];
            REG_TEXT_COLOR:     cfg_in.text_color     = csr_pwdata[7:0];
            REG_DRAW_MODE:      cfg_in.draw_mode      = csr_pwdata[1:0];
            REG_GLYPH_HEIGHT:   cfg_in.glyph_height   = csr_pwdata[4:0];
            REG_FONT_PRESENT:   cfg_in.font_present   = csr_pwdata[0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_SURFACE_WIDTH:  csr_prdata = {19'd0, cfg_ff.surface_width};
         REG_SURFACE_HEIGHT: csr_prdata = {19'd0, cfg_ff.surface_height};
         REG_BYTES_PER_LINE: csr_prdata = {16'd0, cfg_ff.bytes_per_line};
         REG_TEXT_COLOR:     csr_prdata = {24'd0, cfg_ff.text_color};
         REG_DRAW_MODE:      csr_prdata = {30'd0, cfg_ff.draw_mode};
         REG_GLYPH_HEIGHT:   csr_prdata = {27'd0, cfg_ff.glyph_height};
         REG_FONT_PRESENT:   csr_prdata = {31'd0, cfg_ff.font_present};
         default:            csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.surface_width  <= 13'd320;
         cfg_ff.surface_height <= 13'd240;
         cfg_ff.bytes_per_line <= 16'd320;
         cfg_ff.text_color     <= 8'd0;
         cfg_ff.draw_mode      <= MODE_REPLACE;
         cfg_ff.glyph_height   <= 5'd16;
         cfg_ff.font_present   <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### sv/bgb_glyph_store.sv
module bgb_glyph_store (
   input  logic                  clock,
   input  bgb_pkg::store_wr_type wr,
   input  bgb_pkg::store_rd_type rd,
   output logic [7:0]            rd_data
);
   import bgb_pkg::*;

   localparam int DEPTH = 1 << STORE_AW;

   logic [7:0] mem_ff [DEPTH];
   logic [7:0] rd_data_ff;

   assign rd_data = rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
   end

   // read data holds while no new read is issued
   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_data_ff <= mem_ff[rd.addr];
      end
   end

endmodule

### sv/bgb_row_engine.sv
module bgb_row_engine #(
   parameter int MAX_GLYPH_ROWS = bgb_pkg::MAX_GLYPH_ROWS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  bgb_pkg::cfg_type            cfg,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_opcode,
   input  logic signed [15:0]          req_pos_x,
   input  logic signed [15:0]          req_pos_y,
   input  logic [7:0]                  req_char_code,
   output bgb_pkg::store_rd_type       store_rd,
   input  logic [7:0]                  store_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [bgb_pkg::ADDR_W-1:0]  rsp_row_address,
   output logic [7:0]                  rsp_pixel_mask,
   output logic [1:0]                  rsp_pixel_op,
   output logic [7:0]                  rsp_pixel_value,
   output logic                        rsp_last_row
);
   import bgb_pkg::*;

   localparam int HW = $clog2(MAX_GLYPH_ROWS + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CLIP = 2'd1;
   localparam logic [1:0] ST_BASE = 2'd2;
   localparam logic [1:0] ST_ROWS = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic signed [15:0]  x_ff, x_in;
   logic signed [15:0]  y_ff, y_in;
   logic [7:0]          code_ff, code_in;
   logic [HW-1:0]       rows_ff, rows_in;
   logic [HW-1:0]       skip_ff, skip_in;
   logic [HW-1:0]       issued_ff, issued_in;
   logic [2:0]          shift_ff, shift_in;
   logic [7:0]          colmask_ff, colmask_in;
   logic [12:0]         xc_ff, xc_in;
   logic [ADDR_W-1:0]   yprod_ff, yprod_in;
   logic [STORE_AW-1:0] hc_ff, hc_in;
   logic [ADDR_W-1:0]   addr_acc_ff, addr_acc_in;
   logic [STORE_AW-1:0] fidx_ff, fidx_in;
   logic                pend_ff, pend_in;
   logic                pend_last_ff, pend_last_in;
   logic                issue_done_ff, issue_done_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]   rsp_addr_ff, rsp_addr_in;
   logic [7:0]          rsp_mask_ff, rsp_mask_in;
   logic [1:0]          rsp_op_ff, rsp_op_in;
   logic [7:0]          rsp_value_ff, rsp_value_in;
   logic                rsp_last_ff, rsp_last_in;

   // clipping terms
   logic [7:0]          h_wide;
   logic [HW-1:0]       h;
   logic [16:0]         neg_y, neg_x, skip_wide;
   logic                y_hidden, below, left_out, right_out, code_bad, none;
   logic [14:0]         yc, xc_wide;
   logic [12:0]         avail, cols;
   logic [HW-1:0]       skip, rows_raw, rows;
   logic [2:0]          shift;
   logic [7:0]          colmask;
   logic [28:0]         yprod_full;
   logic [HW+7:0]       hc_full;

   // shared adders
   logic [ADDR_W-1:0]   add_a, add_b, add_sum;
   logic [STORE_AW-1:0] idx_a, idx_b, idx_sum;

   logic                accept, issue, consume;
   logic [7:0]          shifted, row_mask;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready && (req_opcode == OP_DRAW);

   always_comb begin
      h_wide    = ({3'd0, cfg.glyph_height} > 8'(MAX_GLYPH_ROWS)) ?
                  8'(MAX_GLYPH_ROWS) : {3'd0, cfg.glyph_height};
      h         = h_wide[HW-1:0];
      neg_y     = 17'd0 - {y_ff[15], y_ff};
      neg_x     = 17'd0 - {x_ff[15], x_ff};
      skip_wide = y_ff[15] ? neg_y : 17'd0;
      y_hidden  = y_ff[15] && (skip_wide >= 17'(h));
      yc        = y_ff[15] ? 15'd0 : y_ff[14:0];
      below     = yc >= {2'd0, cfg.surface_height};
      avail     = cfg.surface_height - yc[12:0];
      skip      = skip_wide[HW-1:0];
      rows_raw  = h - skip;
      rows      = (13'(rows_raw) > avail) ? avail[HW-1:0] : rows_raw;
      left_out  = x_ff[15] && (neg_x >= 17'(GLYPH_WIDTH));
      shift     = x_ff[15] ? neg_x[2:0] : 3'd0;
      xc_wide   = x_ff[15] ? 15'd0 : x_ff[14:0];
      right_out = xc_wide >= {2'd0, cfg.surface_width};
      cols      = cfg.surface_width - xc_wide[12:0];
      for (int k = 0; k < GLYPH_WIDTH; k++) begin
         colmask[k] = 13'(k) < cols;
      end
      code_bad   = 9'(code_ff) >= 9'(GLYPH_COUNT);
      none       = !cfg.font_present || code_bad || y_hidden || below ||
                   (rows == '0) || left_out || right_out;
      yprod_full = yc[12:0] * cfg.bytes_per_line;
      hc_full    = h * code_ff;
   end

   assign consume = pend_ff && (!rsp_valid_ff || rsp_ready);
   assign issue   = (state_ff == ST_ROWS) && !issue_done_ff && (!pend_ff || consume);

   // base setup and per-row stepping go through the same two adders
   always_comb begin
      add_a   = (state_ff == ST_BASE) ? yprod_ff : addr_acc_ff;
      add_b   = (state_ff == ST_BASE) ? ADDR_W'(xc_ff) : ADDR_W'(cfg.bytes_per_line);
      add_sum = add_a + add_b;
      idx_a   = (state_ff == ST_BASE) ? hc_ff : fidx_ff;
      idx_b   = (state_ff == ST_BASE) ? STORE_AW'(skip_ff) : STORE_AW'(1);
      idx_sum = idx_a + idx_b;
   end

   assign store_rd.en   = issue;
   assign store_rd.addr = fidx_ff;

   always_comb begin
      shifted = store_data << shift_ff;
      for (int k = 0; k < GLYPH_WIDTH; k++) begin
         row_mask[k] = shifted[GLYPH_WIDTH-1-k] & colmask_ff[k];
      end
   end

   always_comb begin
      state_in      = state_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      code_in       = code_ff;
      rows_in       = rows_ff;
      skip_in       = skip_ff;
      issued_in     = issued_ff;
      shift_in      = shift_ff;
      colmask_in    = colmask_ff;
      xc_in         = xc_ff;
      yprod_in      = yprod_ff;
      hc_in         = hc_ff;
      addr_acc_in   = addr_acc_ff;
      fidx_in       = fidx_ff;
      pend_in       = pend_ff;
      pend_last_in  = pend_last_ff;
      issue_done_in = issue_done_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_mask_in   = rsp_mask_ff;
      rsp_op_in     = rsp_op_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_last_in   = rsp_last_ff;

      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               x_in     = req_pos_x;
               y_in     = req_pos_y;
               code_in  = req_char_code;
               state_in = ST_CLIP;
            end
         end
         ST_CLIP: begin
            rows_in    = rows;
            skip_in    = skip;
            shift_in   = shift;
            colmask_in = colmask;
            xc_in      = xc_wide[12:0];
            yprod_in   = yprod_full[ADDR_W-1:0];
            hc_in      = STORE_AW'(hc_full);
            state_in   = none ? ST_IDLE : ST_BASE;
         end
         ST_BASE: begin
            addr_acc_in   = add_sum;
            fidx_in       = idx_sum;
            issued_in     = '0;
            issue_done_in = 1'b0;
            pend_in       = 1'b0;
            state_in      = ST_ROWS;
         end
         ST_ROWS: begin
            if (consume) begin
               rsp_valid_in = 1'b1;
               rsp_addr_in  = addr_acc_ff;
               rsp_mask_in  = row_mask;
               rsp_op_in    = cfg.draw_mode;
               rsp_value_in = (cfg.draw_mode == MODE_SET) ? 8'hff : cfg.text_color;
               rsp_last_in  = pend_last_ff;
               addr_acc_in  = add_sum;
               pend_in      = 1'b0;
               if (pend_last_ff) begin
                  state_in = ST_IDLE;
               end
            end
            if (issue) begin
               fidx_in      = idx_sum;
               issued_in    = issued_ff + 1'b1;
               pend_in      = 1'b1;
               pend_last_in = (issued_ff == rows_ff - 1'b1);
               if (issued_ff == rows_ff - 1'b1) begin
                  issue_done_in = 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pend_ff       <= 1'b0;
         issue_done_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_ff       <= pend_in;
         issue_done_ff <= issue_done_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff         <= x_in;
      y_ff         <= y_in;
      code_ff      <= code_in;
      rows_ff      <= rows_in;
      skip_ff      <= skip_in;
      issued_ff    <= issued_in;
      shift_ff     <= shift_in;
      colmask_ff   <= colmask_in;
      xc_ff        <= xc_in;
      yprod_ff     <= yprod_in;
      hc_ff        <= hc_in;
      addr_acc_ff  <= addr_acc_in;
      fidx_ff      <= fidx_in;
      pend_last_ff <= pend_last_in;
      rsp_addr_ff  <= rsp_addr_in;
      rsp_mask_ff  <= rsp_mask_in;
      rsp_op_ff    <= rsp_op_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_row_address = rsp_addr_ff;
   assign rsp_pixel_mask  = rsp_mask_ff;
   assign rsp_pixel_op    = rsp_op_ff;
   assign rsp_pixel_value = rsp_value_ff;
   assign rsp_last_row    = rsp_last_ff;

endmodule

### sv/bgb_checker.sv
module bgb_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_opcode,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [27:0] rsp_row_address,
   input logic [7:0]  rsp_pixel_mask,
   input logic [1:0]  rsp_pixel_op,
   input logic [7:0]  rsp_pixel_value
);
   import bgb_pkg::*;

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_row_address) &&
                                  $stable(rsp_pixel_mask))
      else $error("stalled result changed");

   a_set_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_pixel_op == MODE_SET) |-> rsp_pixel_value == 8'hff)
      else $error("set mode without 0xff value");

   // an accepted draw makes the block busy: req_ready goes low
   a_draw_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_opcode == OP_DRAW) |=> !req_ready)
      else $error("ready during draw setup");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("not idle after reset");

endmodule

bind bitmap_glyph_blitter bgb_checker u_bgb_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .req_opcode      (req_opcode),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_row_address (rsp_row_address),
   .rsp_pixel_mask  (rsp_pixel_mask),
   .rsp_pixel_op    (rsp_pixel_op),
   .rsp_pixel_value (rsp_pixel_value)
);

### tb/tb_bitmap_glyph_blitter.sv
module tb_bitmap_glyph_blitter;
   timeunit 1ns;
   timeprecision 1ps;

   import bgb_pkg::*;

   typedef struct {
      logic               opcode;
      logic [11:0]        font_address;
      logic [7:0]         font_byte;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic [7:0]         char_code;
   } glyph_cmd_type;

   typedef struct {
      logic [27:0] row_address;
      logic [7:0]  pixel_mask;
      logic [1:0]  pixel_op;
      logic [7:0]  pixel_value;
      logic        last_row;
   } row_write_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_opcode = OP_LOAD;
   logic [11:0]        req_font_address = '0;
   logic [7:0]         req_font_byte = '0;
   logic signed [15:0] req_pos_x = '0;
   logic signed [15:0] req_pos_y = '0;
   logic [7:0]         req_char_code = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [27:0]        rsp_row_address;
   logic [7:0]         rsp_pixel_mask;
   logic [1:0]         rsp_pixel_op;
   logic [7:0]         rsp_pixel_value;
   logic               rsp_last_row;
   logic               csr_psel = 1'b0;
   logic               csr_penable = 1'b0;
   logic               csr_pwrite = 1'b0;
   logic [4:0]         csr_paddr = '0;
   logic [31:0]        csr_pwdata = '0;
   logic [31:0]        csr_prdata;
   logic               csr_pready;

   // register copies, reset values
   logic [12:0] cfg_surface_width = 13'd320;
   logic [12:0] cfg_surface_height = 13'd240;
   logic [15:0] cfg_bytes_per_line = 16'd320;
   logic [7:0]  cfg_text_color = 8'd0;
   logic [1:0]  cfg_draw_mode = MODE_REPLACE;
   logic [4:0]  cfg_glyph_height = 5'd16;
   logic        cfg_font_present = 1'b0;

   logic [7:0]  glyph_mem [4096];
   bit          font_loaded [4096];
   int unsigned glyph_pool [8] = '{0, 1, 2, 3, 65, 127, 128, 255};

   glyph_cmd_type pending_cmds [$];
   glyph_cmd_type on_bus;
   row_write_type expected_rows [$];
   int            mismatch_count = 0;
   int            sender_idle_pct = 0;
   int            receiver_stall_pct = 0;

   bitmap_glyph_blitter dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_font_address (req_font_address),
      .req_font_byte    (req_font_byte),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_char_code    (req_char_code),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_row_address  (rsp_row_address),
      .rsp_pixel_mask   (rsp_pixel_mask),
      .rsp_pixel_op     (rsp_pixel_op),
      .rsp_pixel_value  (rsp_pixel_value),
      .rsp_last_row     (rsp_last_row),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int glyph_rows();
      if (cfg_glyph_height > MAX_GLYPH_ROWS_DEF) return MAX_GLYPH_ROWS_DEF;
      return int'(cfg_glyph_height);
   endfunction

   // records a load in the glyph model, or queues the rows of a draw after vertical and horizontal clipping
   task automatic predict_rows(input glyph_cmd_type cmd);
      int x, y, h, skip, rows, shift, cols, sw, sh, r, k;
      logic [11:0] addr;
      logic [7:0] bits;
      longint offset;
      row_write_type w;
      if (cmd.opcode == OP_LOAD) begin
         glyph_mem[cmd.font_address] = cmd.font_byte;
         return;
      end
      if (!cfg_font_present) return;
      x = cmd.pos_x;
      y = cmd.pos_y;
      sw = int'(cfg_surface_width);
      sh = int'(cfg_surface_height);
      h = glyph_rows();
      skip = 0;
      if (y < 0) begin
         if (h + y <= 0) return;
         skip = -y;
         y = 0;
      end
      if (y >= sh) return;
      rows = h - skip;
      if (rows > sh - y) rows = sh - y;
      if (rows <= 0) return;
      shift = 0;
      if (x < 0) begin
         if (-x >= GLYPH_WIDTH) return;
         shift = -x;
         x = 0;
      end
      if (x >= sw) return;
      cols = sw - x;
      for (r = 0; r < rows; r++) begin
         addr = 12'(h * int'(cmd.char_code) + skip + r);
         bits = glyph_mem[addr];
         w.pixel_mask = '0;
         for (k = 0; k + shift < GLYPH_WIDTH && k < cols; k++)
            w.pixel_mask[k] = bits[GLYPH_WIDTH - 1 - shift - k];
         offset = longint'(y + r) * longint'(cfg_bytes_per_line) + longint'(x);
         w.row_address = offset[27:0];
         w.pixel_op = cfg_draw_mode;
         w.pixel_value = (cfg_draw_mode == MODE_SET) ? 8'hFF : cfg_text_color;
         w.last_row = (r == rows - 1);
         expected_rows.push_back(w);
      end
   endtask

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("mismatch %0d at %0t ns: %s", mismatch_count, $realtime, what);
   endtask

   always @(posedge clock) begin : req_driver
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) predict_rows(on_bus);
         if (!req_valid || req_ready) begin
            if (pending_cmds.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               on_bus = pending_cmds.pop_front();
               req_valid <= 1'b1;
               req_opcode <= on_bus.opcode;
               req_font_address <= on_bus.font_address;
               req_font_byte <= on_bus.font_byte;
               req_pos_x <= on_bus.pos_x;
               req_pos_y <= on_bus.pos_y;
               req_char_code <= on_bus.char_code;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : rsp_monitor
      row_write_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rows.size() == 0) begin
               report_mismatch($sformatf("unexpected row transaction, address 0x%07h",
                                         rsp_row_address));
            end else begin
               want = expected_rows.pop_front();
               if (rsp_row_address !== want.row_address)
                  report_mismatch($sformatf("row_address 0x%07h, wanted 0x%07h",
                                            rsp_row_address, want.row_address));
               if (rsp_pixel_mask !== want.pixel_mask)
                  report_mismatch($sformatf("pixel_mask 0x%02h, wanted 0x%02h",
                                            rsp_pixel_mask, want.pixel_mask));
               if (rsp_pixel_op !== want.pixel_op)
                  report_mismatch($sformatf("pixel_op %0d, wanted %0d",
                                            rsp_pixel_op, want.pixel_op));
               if (rsp_pixel_value !== want.pixel_value)
                  report_mismatch($sformatf("pixel_value 0x%02h, wanted 0x%02h",
                                            rsp_pixel_value, want.pixel_value));
               if (rsp_last_row !== want.last_row)
                  report_mismatch($sformatf("last_row %0b, wanted %0b",
                                            rsp_last_row, want.last_row));
            end
         end
         rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         REG_SURFACE_WIDTH:  cfg_surface_width = value[12:0];
         REG_SURFACE_HEIGHT: cfg_surface_height = value[12:0];
         REG_BYTES_PER_LINE: cfg_bytes_per_line = value[15:0];
         REG_TEXT_COLOR:     cfg_text_color = value[7:0];
         REG_DRAW_MODE:      cfg_draw_mode = value[1:0];
         REG_GLYPH_HEIGHT:   cfg_glyph_height = value[4:0];
         REG_FONT_PRESENT:   cfg_font_present = value[0];
         default: ;
      endcase
   endtask

   task automatic configure(input int sw, input int sh, input int pitch, input int color,
                            input int mode, input int gh, input int fp);
      csr_write(REG_SURFACE_WIDTH, sw);
      csr_write(REG_SURFACE_HEIGHT, sh);
      csr_write(REG_BYTES_PER_LINE, pitch);
      csr_write(REG_TEXT_COLOR, color);
      csr_write(REG_DRAW_MODE, mode);
      csr_write(REG_GLYPH_HEIGHT, gh);
      csr_write(REG_FONT_PRESENT, fp);
   endtask

   task automatic set_idling(input int mode);
      case (mode)
         1:       begin sender_idle_pct = 69; receiver_stall_pct = 0;  end
         2:       begin sender_idle_pct = 0;  receiver_stall_pct = 69; end
         3:       begin sender_idle_pct = 30; receiver_stall_pct = 30; end
         default: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
      endcase
   endtask

   // sampled at the falling edge so the driver's updates have settled
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_cmds.size() != 0 || req_valid || expected_rows.size() != 0);
      // a fully clipped draw may still be running
      repeat (25) @(negedge clock);
   endtask

   function automatic logic [7:0] row_byte();
      if ($urandom_range(7) == 0) return 8'h00;
      return 8'($urandom);
   endfunction

   task automatic queue_load(input logic [11:0] addr, input logic [7:0] value);
      glyph_cmd_type c;
      c.opcode = OP_LOAD;
      c.font_address = addr;
      c.font_byte = value;
      c.pos_x = 16'($urandom);
      c.pos_y = 16'($urandom);
      c.char_code = 8'($urandom);
      pending_cmds.push_back(c);
      font_loaded[addr] = 1'b1;
   endtask

   task automatic push_draw(input int code, input int x, input int y);
      glyph_cmd_type c;
      c.opcode = OP_DRAW;
      c.font_address = 12'($urandom);
      c.font_byte = 8'($urandom);
      c.pos_x = 16'(x);
      c.pos_y = 16'(y);
      c.char_code = 8'(code);
      pending_cmds.push_back(c);
   endtask

   // every row of the glyph is loaded before it can be read
   task automatic queue_draw(input int code, input int x, input int y);
      int h, r;
      logic [11:0] a;
      h = glyph_rows();
      for (r = 0; r < h; r++) begin
         a = 12'(h * code + r);
         if (!font_loaded[a]) queue_load(a, row_byte());
      end
      push_draw(code, x, y);
   endtask

   // loads queued ahead of a draw count towards the total
   task automatic random_items(input int count);
      int code, x, y;
      while (pending_cmds.size() < count) begin
         if ($urandom_range(99) < 15) begin
            queue_load(12'($urandom), row_byte());
         end else begin
            if ($urandom_range(1) == 1) code = glyph_pool[$urandom_range(7)];
            else code = $urandom_range(255);
            if ($urandom_range(9) < 8) begin
               x = int'($urandom_range(int'(cfg_surface_width) + 9)) - 8;
               y = int'($urandom_range(int'(cfg_surface_height) + 17)) - 16;
            end else begin
               x = $signed(16'($urandom));
               y = $signed(16'($urandom));
            end
            queue_draw(code, x, y);
         end
      end
   endtask

   initial begin
      set_idling(0);
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // no font after reset: draws give nothing
      queue_load(12'd100, 8'h3C);
      push_draw(0, 0, 0);
      push_draw(65, 40, 40);
      wait_idle();

      configure(320, 240, 320, 8'h5A, MODE_REPLACE, 2, 1);
      queue_load(12'd0, 8'h81);
      queue_load(12'd1, 8'h00);
      queue_load(12'd510, 8'hFF);
      queue_load(12'd511, 8'hA5);
      queue_load(12'd4095, 8'hFF);
      queue_draw(0, 0, 0);
      queue_draw(255, 312, 238);
      queue_draw(255, -7, 5);
      queue_draw(255, -8, 5);
      queue_draw(255, 319, 0);
      queue_draw(255, 320, 0);
      queue_draw(255, 315, 100);
      queue_draw(0, 10, -1);
      queue_draw(0, 10, -2);
      queue_draw(0, 10, 239);
      queue_draw(0, 10, 240);
      queue_draw(0, -32768, -32768);
      queue_draw(255, 32767, 32767);
      wait_idle();

      set_idling(1);
      configure(4096, 4096, 65535, 8'hFF, MODE_XOR, 16, 1);
      random_items(35);
      wait_idle();

      set_idling(2);
      configure(1, 1, 1, 8'h00, MODE_OR, 1, 1);
      random_items(30);
      wait_idle();

      // oversized surface and pitch make the offset wrap; tall glyph height
      set_idling(3);
      configure(8191, 8191, 65535, 8'h33, MODE_SET, 31, 1);
      random_items(35);
      wait_idle();

      set_idling(0);
      configure(320, 240, 320, 8'h11, MODE_REPLACE, 0, 1);
      random_items(6);
      wait_idle();

      set_idling(1);
      configure(0, 0, 320, 8'h22, MODE_XOR, 16, 1);
      random_items(6);
      wait_idle();

      set_idling(2);
      configure($urandom_range(1, 640), $urandom_range(1, 480), $urandom_range(1, 65535),
                $urandom_range(255), $urandom_range(3), $urandom_range(1, 16), 1);
      random_items(40);
      wait_idle();

      set_idling(3);
      configure($urandom_range(1, 640), $urandom_range(1, 480), $urandom_range(1, 65535),
                $urandom_range(255), $urandom_range(3), $urandom_range(1, 16), 1);
      random_items(40);
      wait_idle();

      set_idling(0);
      configure(320, 240, 320, 8'h80, MODE_OR, 16, 0);
      random_items(8);
      wait_idle();

      if (mismatch_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
